// File: rtl/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and helper functions for the bracket checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // default stack depth
    localparam int STACK_DEPTH_DEF = 64;

    // ascii bracket codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_NONE   = 8'h00;

    // bracket kind codes kept on the stack
    localparam logic [1:0] KIND_PAREN = 2'd0;
    localparam logic [1:0] KIND_BRACE = 2'd1;
    localparam logic [1:0] KIND_BRACK = 2'd2;

    // report codes
    localparam logic [1:0] ST_BALANCED   = 2'd0;
    localparam logic [1:0] ST_MISMATCH   = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    // byte classification
    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
    } t_chr;

    // controller to datapath commands
    typedef struct packed {
        logic idle;    // controller waits for bytes
        logic step;    // apply the accepted byte
        logic report;  // load single report and clear
        logic drain;   // emit one closer and pop
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic single;      // string ends with a single report
        logic slot_free;   // output register can take a result
        logic depth_one;   // one opener left
        logic depth_zero;  // stack empty
    } t_stat;

    function automatic t_chr classify(input logic [7:0] c);
        t_chr r;
        r = '0;
        case (c)
            CH_LPAREN: begin r.is_open  = 1'b1; r.kind = KIND_PAREN; end
            CH_LBRACE: begin r.is_open  = 1'b1; r.kind = KIND_BRACE; end
            CH_LBRACK: begin r.is_open  = 1'b1; r.kind = KIND_BRACK; end
            CH_RPAREN: begin r.is_close = 1'b1; r.kind = KIND_PAREN; end
            CH_RBRACE: begin r.is_close = 1'b1; r.kind = KIND_BRACE; end
            CH_RBRACK: begin r.is_close = 1'b1; r.kind = KIND_BRACK; end
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] closer_of(input logic [1:0] kind);
        logic [7:0] r;
        case (kind)
            KIND_PAREN: r = CH_RPAREN;
            KIND_BRACE: r = CH_RBRACE;
            KIND_BRACK: r = CH_RBRACK;
            default:    r = CH_NONE;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ctrl
// Controller: takes bytes while idle, drains leftover openers at string end.
// ----------------------------------------------------------------------------
module bbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_end_of_string,
    output logic          o_in_stall,
    input  bbc_pkg::t_stat i_stat,
    output bbc_pkg::t_cmd  o_cmd
);
    import bbc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // accept bytes only while idle and the output slot can take a report
    assign o_in_stall = !((r_state == S_IDLE) && i_stat.slot_free);
    assign accept     = i_in_valid && !o_in_stall;

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.idle   = (r_state == S_IDLE);
        o_cmd.step   = accept;
        o_cmd.report = accept && i_end_of_string && i_stat.single;
        o_cmd.drain  = (r_state == S_DRAIN) && i_stat.slot_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_end_of_string && !i_stat.single) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (o_cmd.drain && i_stat.depth_one) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/bbc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_dpath
// Datapath: opener stack memory, depth and error flags, output register.
// ----------------------------------------------------------------------------
module bbc_dpath #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_ch,
    input  bbc_pkg::t_cmd  i_cmd,
    output bbc_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_status,
    output logic [7:0]     o_close_char,
    output logic           o_last_result
);
    import bbc_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [1:0]    mem [STACK_DEPTH];
    logic [DW-1:0] r_depth, n_depth, depth_b;
    logic          r_mis, n_mis, mis_b;
    logic          r_ovf, n_ovf, ovf_b;
    logic [1:0]    r_top;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [7:0]    r_close;
    logic          r_last;

    t_chr          chr;
    logic          blocked, push, pop_b, clear, load;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] rd_lin;

    // effect of the current byte on depth and flags
    always_comb begin
        chr     = classify(i_ch);
        blocked = r_mis || r_ovf;
        push    = 1'b0;
        pop_b   = 1'b0;
        mis_b   = r_mis;
        ovf_b   = r_ovf;
        depth_b = r_depth;
        if (!blocked && chr.is_open) begin
            if (r_depth == DW'(STACK_DEPTH)) begin
                ovf_b = 1'b1;
            end else begin
                push    = i_cmd.step;
                depth_b = r_depth + DW'(1);
            end
        end else if (!blocked && chr.is_close) begin
            if (r_depth == '0 || r_top != chr.kind) begin
                mis_b = 1'b1;
            end else begin
                pop_b   = i_cmd.step;
                depth_b = r_depth - DW'(1);
            end
        end
    end

    // status toward the controller
    always_comb begin
        o_stat            = '0;
        o_stat.single     = mis_b || ovf_b || (depth_b == '0);
        o_stat.slot_free  = !r_out_valid || !i_out_stall;
        o_stat.depth_one  = (r_depth == DW'(1));
        o_stat.depth_zero = (r_depth == '0);
    end

    // next depth and flags
    assign clear = i_cmd.report || (i_cmd.drain && o_stat.depth_one);
    always_comb begin
        n_depth = r_depth;
        n_mis   = r_mis;
        n_ovf   = r_ovf;
        if (clear) begin
            n_depth = '0;
            n_mis   = 1'b0;
            n_ovf   = 1'b0;
        end else if (i_cmd.drain) begin
            n_depth = r_depth - DW'(1);
        end else if (i_cmd.step) begin
            n_depth = depth_b;
            n_mis   = mis_b;
            n_ovf   = ovf_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_mis   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_mis   <= n_mis;
            r_ovf   <= n_ovf;
        end
    end

    // stack memory, top entry kept in a registered read with push bypass
    assign wr_addr = r_depth[AW-1:0];
    assign rd_lin  = n_depth - DW'(1);
    assign rd_addr = rd_lin[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[wr_addr] <= chr.kind;
        end
        if (push) begin
            r_top <= chr.kind;
        end else begin
            r_top <= mem[rd_addr];
        end
    end

    // output register
    assign load = i_cmd.report || i_cmd.drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_status <= ovf_b ? ST_OVERFLOW : (mis_b ? ST_MISMATCH : ST_BALANCED);
            r_close  <= CH_NONE;
            r_last   <= 1'b1;
        end else if (i_cmd.drain) begin
            r_status <= ST_INCOMPLETE;
            r_close  <= closer_of(r_top);
            r_last   <= o_stat.depth_one;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_close_char  = r_close;
    assign o_last_result = r_last;

endmodule

// File: rtl/bracket_balance_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Checks bracket balance of a byte stream and completes unclosed openers.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one byte of the string per item (i_ch) with i_end_of_string
//   set on the final byte. Output channel: result items (o_status,
//   o_close_char, o_last_result). Both channels use valid and stall.
//   Bytes may follow back to back; a byte without end of string gives no result.
//   A balanced or failed string's report sits in the output register right
//   after the edge that accepts its final byte; for an incomplete string the
//   first completion closer follows in the drain state, after the top is read.
//   For an incomplete string the block emits one closer per remaining opener,
//   one per cycle unless the output stalls, top of stack first; the single
//   read port of the stack sets this pace. No bytes are taken during the drain.
//   Bytes are taken only while the output register is empty or being read,
//   so a stalled receiver holds back the input side as well.
//   Reset (synchronous, active low) empties the stack, clears the error
//   flags and drops output valid. Stack contents need no clearing pass.
//   Stack depth is set by STACK_DEPTH (2 to 64).
// ----------------------------------------------------------------------------
module bracket_balance_checker_top #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_close_char,
    output logic       o_last_result
);
    import bbc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // controller
    bbc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_end_of_string (i_end_of_string),
        .o_in_stall      (o_in_stall),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // datapath
    bbc_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (i_ch),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_close_char  (o_close_char),
        .o_last_result (o_last_result)
    );

    // report and drain never issue together
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.report && cmd.drain))
        else $error("report and drain issued together");

    // no byte taken during drain
    a_no_take_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cmd.idle |-> !cmd.step)
        else $error("byte accepted while draining");

    // end of string leaves an empty stack
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.report || (cmd.drain && stat.depth_one)) |=> (stat.depth_zero && cmd.idle))
        else $error("stack not empty after string end");

endmodule
